### rtl/gprm_pkg.sv
// Package with the payload types and constants of the gated pose running mean.
package gprm_pkg;

  localparam int unsigned CntW = 10;

  typedef enum logic [1:0] {
    REG_TRANS_GATE = 2'd0,
    REG_ROT_GATE   = 2'd1,
    REG_MAX_SAMPLES = 2'd2
  } reg_idx_e;

  typedef struct packed {
    logic               req_type;
    logic signed [31:0] tx;
    logic signed [31:0] ty;
    logic signed [31:0] tz;
    logic signed [31:0] rx;
    logic signed [31:0] ry;
    logic signed [31:0] rz;
  } gprm_in_t;

  typedef struct packed {
    logic signed [31:0] out_tx;
    logic signed [31:0] out_ty;
    logic signed [31:0] out_tz;
    logic signed [31:0] out_rx;
    logic signed [31:0] out_ry;
    logic signed [31:0] out_rz;
    logic               from_mean;
  } gprm_out_t;

endpackage

### rtl/gated_pose_running_mean.sv
// Top level of the gated pose running mean with its shared divider sequencer.
//
// Usage: frame events enter as transfers on the in channel (in_valid_i, in_ready_o,
// in_data_i). A marker pose updates the running sums, a frame without a marker
// asks for the held mean. At most one result leaves as a transfer on the out
// channel (out_valid_o, out_ready_i, out_data_o).
// Configuration: the three registers are written through cfg_valid_i/cfg_ready_o
// with an index and data; writes are taken at any time, but should be made while
// the block is idle.
// Division: each of the six mean components is produced in turn by one restoring
// divider that retires one quotient bit per cycle. A frame without a marker on an
// empty filter is dropped without a result.
// Throughput: one item at a time; in_ready_o is high only while the sequencer
// waits for work, and rises again once the wait state has seen the result taken.
// Reset: sums and count are cleared and the gates take their default values.
// Stalls: a finished result is held in the output register until the receiver
// takes it; the next item is accepted only once the result has been transferred.
module gated_pose_running_mean
  import gprm_pkg::*;
#(
  parameter int unsigned SUM_WIDTH = 42
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_ready_o,
  input  gprm_in_t  in_data_i,
  output logic      out_valid_o,
  input  logic      out_ready_i,
  output gprm_out_t out_data_o,
  input  logic      cfg_valid_i,
  output logic      cfg_ready_o,
  input  logic [1:0]  cfg_index_i,
  input  logic [31:0] cfg_data_i
);

  localparam int unsigned SW = SUM_WIDTH;
  localparam int unsigned DivW = SW + 1;
  localparam int unsigned BitCntW = $clog2(DivW + 2);

  typedef enum logic [6:0] {
    S_IDLE  = 7'b0000001,
    S_SEED  = 7'b0000010,
    S_DIV   = 7'b0000100,
    S_DIST  = 7'b0001000,
    S_DEC   = 7'b0010000,
    S_OUT   = 7'b0100000,
    S_WAIT  = 7'b1000000
  } state_e;

  state_e state_q, state_d;

  logic [15:0]     trans_gate_q, rot_gate_q;
  logic [CntW-1:0] max_samples_q;
  logic [SW-1:0]   sum_q [6];
  logic [CntW-1:0] count_q;
  gprm_in_t        item_q;
  logic signed [31:0] mean_q [6];
  logic [2:0]      comp_q;
  logic [BitCntW-1:0] bit_q;
  logic [DivW-1:0] num_q;  // magnitude plus half count, shifted out MSB first
  logic [CntW:0]   rem_q;
  logic [DivW-1:0] quo_q;
  logic            neg_q;
  logic [33:0]     dist_q [2];
  logic            far_q [2];
  logic            out_valid_q;
  gprm_out_t       out_q;

  assign cfg_ready_o = 1'b1;
  assign in_ready_o  = (state_q == S_IDLE);
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  function automatic logic signed [31:0] comp_of(gprm_in_t d, logic [2:0] k);
    case (k)
      3'd0:    comp_of = d.tx;
      3'd1:    comp_of = d.ty;
      3'd2:    comp_of = d.tz;
      3'd3:    comp_of = d.rx;
      3'd4:    comp_of = d.ry;
      default: comp_of = d.rz;
    endcase
  endfunction

  // Magnitude and sign of the selected sum.
  logic [SW-1:0]   cur_sum;
  logic            cur_neg;
  logic [SW:0]     cur_mag;
  assign cur_sum = sum_q[comp_q];
  assign cur_neg = cur_sum[SW-1];
  assign cur_mag = cur_neg ? ({1'b0, ~cur_sum} + 1'b1) : {1'b0, cur_sum};

  // One restoring division step.
  logic [CntW:0] trial;
  logic          fits;
  assign trial = {rem_q[CntW-1:0], num_q[DivW-1]};
  assign fits  = trial >= {1'b0, count_q};

  // Saturated signed result of the finished division.
  logic signed [31:0] sat_mean;
  always_comb begin
    if (neg_q) begin
      sat_mean = (quo_q >= DivW'(33'h80000000)) ? 32'sh80000000 : -$signed(quo_q[31:0]);
    end else begin
      sat_mean = (quo_q > DivW'(32'h7FFFFFFF)) ? 32'sh7FFFFFFF : $signed(quo_q[31:0]);
    end
  end

  // Distance of one component, squared.
  logic signed [32:0] diff;
  logic [32:0]        adiff;
  logic [31:0]        sq;
  assign diff  = 33'(mean_q[comp_q]) - 33'(comp_of(item_q, comp_q));
  assign adiff = diff[32] ? 33'(-diff) : 33'(diff);
  assign sq    = adiff[15:0] * adiff[15:0];

  logic grp;
  assign grp = (comp_q >= 3'd3);

  logic t_in, r_in;
  assign t_in = !far_q[0] && (dist_q[0] < 34'(trans_gate_q * trans_gate_q));
  assign r_in = !far_q[1] && (dist_q[1] < 34'(rot_gate_q * rot_gate_q));

  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE: if (in_valid_i) state_d = S_SEED;
      S_SEED: begin
        if (item_q.req_type && count_q == '0) state_d = S_IDLE;
        else state_d = S_DIV;
      end
      S_DIV:  if (bit_q == BitCntW'(DivW + 1)) state_d = (comp_q == 3'd5) ?
                (item_q.req_type ? S_OUT : S_DIST) : S_DIV;
      S_DIST: if (comp_q == 3'd5) state_d = S_DEC;
      S_DEC:  state_d = S_OUT;
      S_OUT:  state_d = S_WAIT;
      S_WAIT: if (!out_valid_q) state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q       <= S_IDLE;
      trans_gate_q  <= 16'd1966;
      rot_gate_q    <= 16'd6554;
      max_samples_q <= CntW'(100);
      count_q       <= '0;
      out_valid_q   <= 1'b0;
      comp_q        <= '0;
      bit_q         <= '0;
      for (int i = 0; i < 6; i++) sum_q[i] <= '0;
    end else begin
      state_q <= state_d;
      if (cfg_valid_i) begin
        case (cfg_index_i)
          REG_TRANS_GATE:  trans_gate_q  <= cfg_data_i[15:0];
          REG_ROT_GATE:    rot_gate_q    <= cfg_data_i[15:0];
          REG_MAX_SAMPLES: max_samples_q <= cfg_data_i[CntW-1:0];
          default: ;
        endcase
      end
      if (out_valid_q && out_ready_i) out_valid_q <= 1'b0;
      case (state_q)
        S_IDLE: begin
          if (in_valid_i) item_q <= in_data_i;
          comp_q <= '0;
          bit_q  <= '0;
        end
        S_SEED: begin
          if (!item_q.req_type && count_q == '0) begin
            for (int i = 0; i < 6; i++) sum_q[i] <= SW'(comp_of(item_q, 3'(i)));
            count_q <= CntW'(1);
          end
        end
        S_DIV: begin
          if (bit_q == '0) begin
            num_q <= DivW'(cur_mag) + DivW'(count_q >> 1);
            neg_q <= cur_neg;
            rem_q <= '0;
            quo_q <= '0;
            bit_q <= bit_q + 1'b1;
          end else if (bit_q != BitCntW'(DivW + 1)) begin
            rem_q <= fits ? (trial - {1'b0, count_q}) : trial;
            quo_q <= {quo_q[DivW-2:0], fits};
            num_q <= num_q << 1;
            bit_q <= bit_q + 1'b1;
          end else begin
            // All quotient bits are in; store the mean and move on.
            mean_q[comp_q] <= sat_mean;
            bit_q <= '0;
            comp_q <= (comp_q == 3'd5) ? 3'd0 : comp_q + 1'b1;
            dist_q[0] <= '0; dist_q[1] <= '0;
            far_q[0]  <= 1'b0; far_q[1] <= 1'b0;
          end
        end
        S_DIST: begin
          dist_q[grp] <= dist_q[grp] + 34'(sq);
          if (adiff >= 33'd65536) far_q[grp] <= 1'b1;
          comp_q <= (comp_q == 3'd5) ? 3'd0 : comp_q + 1'b1;
        end
        S_DEC: begin
          if (t_in && r_in && !(count_q < max_samples_q)) begin
            out_q.out_tx <= mean_q[0]; out_q.out_ty <= mean_q[1];
            out_q.out_tz <= mean_q[2]; out_q.out_rx <= mean_q[3];
            out_q.out_ry <= mean_q[4]; out_q.out_rz <= mean_q[5];
            out_q.from_mean <= 1'b1;
          end else begin
            out_q.out_tx <= item_q.tx; out_q.out_ty <= item_q.ty; out_q.out_tz <= item_q.tz;
            out_q.out_rx <= item_q.rx; out_q.out_ry <= item_q.ry; out_q.out_rz <= item_q.rz;
            out_q.from_mean <= 1'b0;
          end
          if (t_in && r_in) begin
            if (count_q < max_samples_q) begin
              for (int i = 0; i < 6; i++)
                sum_q[i] <= sum_q[i] + SW'(comp_of(item_q, 3'(i)));
              count_q <= count_q + 1'b1;
            end
          end else begin
            for (int i = 0; i < 6; i++) sum_q[i] <= SW'(comp_of(item_q, 3'(i)));
            count_q <= CntW'(1);
          end
        end
        S_OUT: begin
          out_valid_q <= 1'b1;
          if (item_q.req_type) begin
            out_q.out_tx <= mean_q[0]; out_q.out_ty <= mean_q[1];
            out_q.out_tz <= mean_q[2]; out_q.out_rx <= mean_q[3];
            out_q.out_ry <= mean_q[4]; out_q.out_rz <= mean_q[5];
            out_q.from_mean <= 1'b1;
          end
        end
        default: ;
      endcase
    end
  end

`ifndef SYNTH
  a_ready_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_ready_o |-> !out_valid_o) else $error("ready while a result is pending");
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(out_data_o))
    else $error("result changed while stalled");
  a_count_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_DEC |=> count_q != '0) else $error("count empty after decision");
`endif

endmodule

### test/tb.sv
// Self-checking testbench for the gated pose running mean, with its scoreboard class.
module tb;
  import gprm_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int SumW = 42;
  // Enough cycles for the slowest item to work its way through all six divisions.
  localparam int SettleCycles = 400;
  localparam logic [1:0] RegUnused = 2'd3;

  // The scoreboard keeps its own copy of the filter state and the registers, and
  // works out the published pose for every frame event that the block takes.
  class pose_mean_scoreboard;
    logic [15:0]     trans_gate;
    logic [15:0]     rot_gate;
    logic [9:0]      max_samples;
    logic [SumW-1:0] t_sum[3];
    logic [SumW-1:0] r_sum[3];
    logic [9:0]      count;
    gprm_out_t       pose_q[$];
    int unsigned     errors;
    int unsigned     results;
    int unsigned     mean_results;
    int unsigned     silent_frames;

    function new();
      trans_gate  = 16'd1966;
      rot_gate    = 16'd6554;
      max_samples = 10'd100;
      for (int i = 0; i < 3; i++) begin
        t_sum[i] = '0;
        r_sum[i] = '0;
      end
      count = '0;
    endfunction

    function void write_reg(logic [1:0] idx, logic [31:0] data);
      case (idx)
        REG_TRANS_GATE:  trans_gate  = data[15:0];
        REG_ROT_GATE:    rot_gate    = data[15:0];
        REG_MAX_SAMPLES: max_samples = data[9:0];
        default: ;
      endcase
    endfunction

    // Sum over count, rounded half away from zero and clamped to 32 bits.
    function longint rounded_mean(logic [SumW-1:0] s, logic [9:0] c);
      logic signed [SumW-1:0] ss;
      longint sv;
      longint unsigned mag;
      longint unsigned q;
      longint unsigned cc;
      ss  = s;
      sv  = ss;
      cc  = (c == 0) ? 1 : c;
      mag = (sv < 0) ? -sv : sv;
      q   = (mag + cc / 2) / cc;
      if (sv < 0) begin
        if (q >= 64'h8000_0000) return -64'sh8000_0000;
        return -longint'(q);
      end
      if (q > 64'h7FFF_FFFF) return 64'sh7FFF_FFFF;
      return longint'(q);
    endfunction

    function bit in_gate(longint m[3], longint v[3], logic [15:0] g);
      longint unsigned acc;
      longint unsigned a;
      longint d;
      acc = 0;
      for (int i = 0; i < 3; i++) begin
        d = m[i] - v[i];
        a = (d < 0) ? -d : d;
        if (a >= 65536) return 1'b0;
        acc += a * a;
      end
      return acc < longint'(g) * longint'(g);
    endfunction

    function void reseed(longint tv[3], longint rv[3]);
      for (int i = 0; i < 3; i++) begin
        t_sum[i] = SumW'(tv[i]);
        r_sum[i] = SumW'(rv[i]);
      end
      count = 10'd1;
    endfunction

    function void note_input(gprm_in_t x);
      longint tv[3];
      longint rv[3];
      longint tm[3];
      longint rm[3];
      gprm_out_t o;
      bit use_mean;
      tv[0] = x.tx; tv[1] = x.ty; tv[2] = x.tz;
      rv[0] = x.rx; rv[1] = x.ry; rv[2] = x.rz;
      use_mean = 1'b0;
      if (x.req_type) begin
        // A frame without a marker publishes nothing until a sample exists.
        if (count == 0) begin
          silent_frames++;
          return;
        end
        use_mean = 1'b1;
      end else begin
        if (count == 0) reseed(tv, rv);
        for (int i = 0; i < 3; i++) begin
          tm[i] = rounded_mean(t_sum[i], count);
          rm[i] = rounded_mean(r_sum[i], count);
        end
        if (in_gate(tm, tv, trans_gate) && in_gate(rm, rv, rot_gate)) begin
          if (count < max_samples) begin
            for (int i = 0; i < 3; i++) begin
              t_sum[i] = t_sum[i] + SumW'(tv[i]);
              r_sum[i] = r_sum[i] + SumW'(rv[i]);
            end
            count = count + 10'd1;
          end else begin
            use_mean = 1'b1;
          end
        end else begin
          reseed(tv, rv);
        end
      end
      if (use_mean) begin
        for (int i = 0; i < 3; i++) begin
          tm[i] = rounded_mean(t_sum[i], count);
          rm[i] = rounded_mean(r_sum[i], count);
        end
        o.out_tx = 32'(tm[0]); o.out_ty = 32'(tm[1]); o.out_tz = 32'(tm[2]);
        o.out_rx = 32'(rm[0]); o.out_ry = 32'(rm[1]); o.out_rz = 32'(rm[2]);
        o.from_mean = 1'b1;
      end else begin
        o.out_tx = x.tx; o.out_ty = x.ty; o.out_tz = x.tz;
        o.out_rx = x.rx; o.out_ry = x.ry; o.out_rz = x.rz;
        o.from_mean = 1'b0;
      end
      pose_q.insert(pose_q.size(), o);
    endfunction

    task report(string field, logic [31:0] got, logic [31:0] want);
      $display("%0t mismatch on %s: got %h, expected %h", $realtime, field, got, want);
      errors++;
    endtask

    task check_result(gprm_out_t got);
      gprm_out_t want;
      results++;
      if (got.from_mean) mean_results++;
      if (pose_q.size() == 0) begin
        report("unexpected result", got.out_tx, '0);
        return;
      end
      want = pose_q.pop_front();
      if (got.out_tx !== want.out_tx) report("out_tx", got.out_tx, want.out_tx);
      if (got.out_ty !== want.out_ty) report("out_ty", got.out_ty, want.out_ty);
      if (got.out_tz !== want.out_tz) report("out_tz", got.out_tz, want.out_tz);
      if (got.out_rx !== want.out_rx) report("out_rx", got.out_rx, want.out_rx);
      if (got.out_ry !== want.out_ry) report("out_ry", got.out_ry, want.out_ry);
      if (got.out_rz !== want.out_rz) report("out_rz", got.out_rz, want.out_rz);
      if (got.from_mean !== want.from_mean) report("from_mean", got.from_mean, want.from_mean);
    endtask
  endclass

  logic        clk_i;
  logic        rst_ni;
  logic        in_valid_i;
  logic        in_ready_o;
  gprm_in_t    in_data_i;
  logic        out_valid_o;
  logic        out_ready_i;
  gprm_out_t   out_data_o;
  logic        cfg_valid_i;
  logic        cfg_ready_o;
  logic [1:0]  cfg_index_i;
  logic [31:0] cfg_data_i;

  pose_mean_scoreboard pose_sb = new();
  int unsigned items_sent;
  int unsigned burst_left;

  gated_pose_running_mean #(
    .SUM_WIDTH(SumW)
  ) i_dut (
    .clk_i,
    .rst_ni,
    .in_valid_i,
    .in_ready_o,
    .in_data_i,
    .out_valid_o,
    .out_ready_i,
    .out_data_o,
    .cfg_valid_i,
    .cfg_ready_o,
    .cfg_index_i,
    .cfg_data_i
  );

  always begin
    clk_i = 1'b1;
    #5;
    clk_i = 1'b0;
    #5;
  end

  // Outputs only move at rising edges, so the levels seen at the falling edge are
  // exactly the ones the block sees at the next rising edge.
  always @(negedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i) pose_sb.check_result(out_data_o);
  end

  // The receiver stalls on a rotating pattern, sometimes not at all, and once
  // holds off for a long stretch so that the block backs up and stops taking
  // transfers on its input.
  initial begin
    logic [15:0] stall_pattern;
    int unsigned hold_cycles;
    int unsigned mode_left;
    bit          free_run;
    bit          long_hold_done;
    stall_pattern  = 16'b1011_0010_1110_0001;
    hold_cycles    = 0;
    mode_left      = 0;
    free_run       = 1'b0;
    long_hold_done = 1'b0;
    out_ready_i    = 1'b0;
    forever begin
      @(posedge clk_i);
      if (!long_hold_done && pose_sb.results >= 250) begin
        long_hold_done = 1'b1;
        hold_cycles    = 3000;
      end
      if (mode_left == 0) begin
        mode_left = $urandom_range(50, 2000);
        free_run  = ($urandom_range(0, 2) == 0);
      end
      mode_left--;
      stall_pattern = {stall_pattern[14:0], stall_pattern[15]};
      if (hold_cycles > 0) begin
        hold_cycles--;
        out_ready_i <= 1'b0;
      end else begin
        out_ready_i <= free_run | stall_pattern[0];
      end
    end
  end

  initial begin
    #20ms;
    $display("Timed out waiting for the block to finish.");
    $display("Regression FAIL");
    $finish;
  end

  // Offers one frame event and returns once it is taken, after a random idle gap at the end of a burst.
  // The valid stays up between back-to-back transfers within a burst.
  task automatic send_frame(gprm_in_t x);
    in_data_i  <= x;
    in_valid_i <= 1'b1;
    do @(negedge clk_i); while (!in_ready_o);
    @(posedge clk_i);
    pose_sb.note_input(x);
    items_sent++;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 20);
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 12)) @(posedge clk_i);
    end else begin
      burst_left--;
    end
  endtask

  // Writes one register and then leaves the channel idle.
  task automatic write_reg(logic [1:0] idx, logic [31:0] data);
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    cfg_valid_i <= 1'b1;
    do @(negedge clk_i); while (!cfg_ready_o);
    @(posedge clk_i);
    pose_sb.write_reg(idx, data);
    cfg_valid_i <= 1'b0;
    @(posedge clk_i);
  endtask

  // Lets every expected pose come out, then allows for a last silent frame.
  task automatic wait_idle();
    in_valid_i <= 1'b0;
    while (pose_sb.pose_q.size() != 0) @(posedge clk_i);
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  function automatic gprm_in_t frame(logic rt, logic [31:0] t0, logic [31:0] t1,
                                     logic [31:0] t2, logic [31:0] r0, logic [31:0] r1,
                                     logic [31:0] r2);
    gprm_in_t x;
    x.req_type = rt;
    x.tx = t0; x.ty = t1; x.tz = t2;
    x.rx = r0; x.ry = r1; x.rz = r2;
    return x;
  endfunction

  initial begin
    gprm_in_t    x;
    logic [31:0] centre[6];
    int          spread;
    int unsigned pick;
    logic [15:0] tg_set[6];
    logic [15:0] rg_set[6];
    logic [9:0]  ms_set[6];

    rst_ni      = 1'b0;
    in_valid_i  = 1'b0;
    in_data_i   = '0;
    cfg_valid_i = 1'b0;
    cfg_index_i = '0;
    cfg_data_i  = '0;
    items_sent  = 0;
    burst_left  = 0;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed part under the reset settings. A frame without a marker on an
    // empty filter must stay silent.
    send_frame(frame(1'b1, '1, '1, '1, '1, '1, '1));
    send_frame(frame(1'b0, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
                     32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF));
    send_frame(frame(1'b0, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
                     32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF));
    send_frame(frame(1'b1, '0, '0, '0, '0, '0, '0));
    send_frame(frame(1'b0, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
                     32'h8000_0000, 32'h8000_0000, 32'h8000_0000));
    // A component exactly one metre off falls outside the gate whatever its size.
    send_frame(frame(1'b0, 32'h8001_0000, 32'h8000_0000, 32'h8000_0000,
                     32'h8000_0000, 32'h8000_0000, 32'h8000_0000));
    send_frame(frame(1'b1, '0, '0, '0, '0, '0, '0));
    // Rounding: a mean of a half must go away from zero on both sides.
    send_frame(frame(1'b0, '0, '0, '0, '0, '0, '0));
    send_frame(frame(1'b0, 32'd1, -32'sd1, 32'd0, 32'd1, -32'sd1, 32'd0));
    send_frame(frame(1'b1, '0, '0, '0, '0, '0, '0));
    // Right at the edge of the translation gate, then just inside it.
    send_frame(frame(1'b0, 32'd1966, 32'd0, 32'd0, 32'd0, 32'd0, 32'd0));
    send_frame(frame(1'b0, 32'd0, 32'd0, 32'd0, 32'd0, 32'd0, 32'd0));
    send_frame(frame(1'b0, 32'd0, 32'd1965, 32'd0, 32'd0, 32'd0, 32'd6553));
    send_frame(frame(1'b1, '0, '0, '0, '0, '0, '0));
    wait_idle();
    // With a limit of one every pose inside the gate returns the mean.
    write_reg(REG_MAX_SAMPLES, 32'hFFFF_FC01);
    send_frame(frame(1'b0, 32'd100, 32'd200, -32'sd300, 32'd5, 32'd6, 32'd7));
    send_frame(frame(1'b0, 32'd101, 32'd201, -32'sd301, 32'd6, 32'd5, 32'd8));
    send_frame(frame(1'b1, '0, '0, '0, '0, '0, '0));
    wait_idle();
    // An index past the register list must change nothing.
    write_reg(RegUnused, 32'h0000_0000);

    // Random part: six settings, gates and limits at both ends among them.
    tg_set = '{16'd1966, 16'hFFFF, 16'd0, 16'd3000, 16'hFFFF, 16'd2000};
    rg_set = '{16'd6554, 16'hFFFF, 16'd0, 16'd9000, 16'hFFFF, 16'd7000};
    ms_set = '{10'd100, 10'd1023, 10'd5, 10'd3, 10'd1, 10'd0};
    for (int i = 0; i < 6; i++) centre[i] = $urandom();
    for (int p = 0; p < 6; p++) begin
      write_reg(REG_TRANS_GATE, {16'($urandom()), tg_set[p]});
      write_reg(REG_ROT_GATE, {16'($urandom()), rg_set[p]});
      write_reg(REG_MAX_SAMPLES, {22'($urandom()), ms_set[p]});
      for (int n = 0; n < 100; n++) begin
        pick = $urandom_range(0, 99);
        if (pick < 8) begin
          // The marker jumps to a new place; the filter has to reseed.
          for (int i = 0; i < 6; i++) centre[i] = $urandom();
        end
        x.req_type = (pick >= 88);
        if (pick >= 94) begin
          x = frame(1'b1, $urandom(), $urandom(), $urandom(), $urandom(), $urandom(),
                    $urandom());
        end else begin
          // Mostly jitter small enough to stay inside the gate, now and then more.
          spread = ($urandom_range(0, 9) == 0) ? 40000 : $urandom_range(0, 1200);
          x.tx = centre[0] + $urandom_range(0, 2 * spread) - spread;
          x.ty = centre[1] + $urandom_range(0, 2 * spread) - spread;
          x.tz = centre[2] + $urandom_range(0, 2 * spread) - spread;
          x.rx = centre[3] + $urandom_range(0, 2 * spread) - spread;
          x.ry = centre[4] + $urandom_range(0, 2 * spread) - spread;
          x.rz = centre[5] + $urandom_range(0, 2 * spread) - spread;
        end
        send_frame(x);
      end
      wait_idle();
    end

    $display("Sent %0d frame events over six gate settings; %0d poses came out,",
             items_sent, pose_sb.results);
    $display("%0d of them means, and %0d frames were rightly silent.",
             pose_sb.mean_results, pose_sb.silent_frames);
    if (pose_sb.errors == 0 && pose_sb.pose_q.size() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
